FILE: rtl/ufa_pkg.sv
// shared types and constants for the unit pool admission block
package ufa_pkg;

  localparam int NumKinds   = 4;
  localparam int QueueDepth = 16;

  localparam int KindW   = 2;
  localparam int DataW   = 32;
  localparam int FreeW   = 4;
  localparam int QIdxW   = $clog2(QueueDepth);
  localparam int FillW   = $clog2(QueueDepth + 1);
  localparam int EntryW  = 2 * DataW;
  localparam int RamDepth = NumKinds * QueueDepth;
  localparam int AddrW   = $clog2(RamDepth);

  localparam logic [FreeW-1:0] FreeMax   = FreeW'(15);
  localparam logic [FreeW-1:0] FreeReset = FreeW'(1);

  typedef enum logic {
    OP_REQUEST  = 1'b0,
    OP_COMPLETE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    RES_START   = 2'd0,
    RES_QUEUED  = 2'd1,
    RES_DROPPED = 2'd2,
    RES_DONE    = 2'd3
  } res_kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_POP
  } state_e;

  typedef struct packed {
    logic load;
    logic exec;
    logic pop;
  } cmd_t;

  typedef struct packed {
    logic pop_needed;
  } status_t;

endpackage

FILE: rtl/ufa_ram.sv
// generic single write port RAM with registered read
module ufa_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/ufa_ctrl.sv
// sequencing state machine for the unit pool admission block
module ufa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  ufa_pkg::status_t  status_i,
  output ufa_pkg::cmd_t     cmd_o,
  output logic              busy
);
  import ufa_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = status_i.pop_needed ? ST_POP : ST_IDLE;
      end
      ST_POP: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o = '0;
    busy  = 1'b1;
    case (state_q)
      ST_IDLE: begin
        busy       = 1'b0;
        cmd_o.load = start;
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
      end
      ST_POP: begin
        cmd_o.pop = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

FILE: rtl/ufa_dp.sv
// counters, queue pointers, wait store and result register
module ufa_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ufa_pkg::cmd_t               cmd_i,
  output ufa_pkg::status_t            status_o,
  input  logic                        op_i,
  input  logic [ufa_pkg::KindW-1:0]   unit_kind_i,
  input  logic [ufa_pkg::DataW-1:0]   duration_i,
  input  logic [ufa_pkg::DataW-1:0]   tag_i,
  input  logic                        cfg_we_i,
  input  logic [ufa_pkg::KindW-1:0]   cfg_index_i,
  input  logic [ufa_pkg::FreeW-1:0]   cfg_data_i,
  output logic                        strobe_o,
  output logic [1:0]                  result_kind_o,
  output logic [ufa_pkg::KindW-1:0]   out_kind_o,
  output logic [ufa_pkg::DataW-1:0]   out_duration_o,
  output logic [ufa_pkg::DataW-1:0]   out_tag_o,
  output logic                        last_o
);
  import ufa_pkg::*;

  function automatic logic [QIdxW-1:0] next_slot(input logic [QIdxW-1:0] slot);
    next_slot = (slot == QIdxW'(QueueDepth - 1)) ? '0 : QIdxW'(slot + 1'b1);
  endfunction

  function automatic logic [AddrW-1:0] slot_addr(input logic [KindW-1:0] kind,
                                                 input logic [QIdxW-1:0] slot);
    slot_addr = AddrW'(AddrW'(kind) * AddrW'(QueueDepth)) + AddrW'(slot);
  endfunction

  // latched transaction
  op_e              op_q;
  logic [KindW-1:0] kind_q;
  logic [DataW-1:0] dur_q, tag_q;

  logic [FreeW-1:0] free_q [NumKinds];
  logic [FreeW-1:0] free_d [NumKinds];
  logic [QIdxW-1:0] head_q [NumKinds];
  logic [QIdxW-1:0] head_d [NumKinds];
  logic [QIdxW-1:0] tail_q [NumKinds];
  logic [QIdxW-1:0] tail_d [NumKinds];
  logic [FillW-1:0] fill_q [NumKinds];
  logic [FillW-1:0] fill_d [NumKinds];

  logic [FreeW-1:0] free_k, free_inc;
  logic [FillW-1:0] fill_k;

  logic              ram_we;
  logic [AddrW-1:0]  ram_waddr, ram_raddr;
  logic [EntryW-1:0] ram_rdata;

  logic              valid_q, valid_d;
  res_kind_e         rkind_q, rkind_d;
  logic [KindW-1:0]  okind_q, okind_d;
  logic [DataW-1:0]  odur_q, odur_d;
  logic [DataW-1:0]  otag_q, otag_d;
  logic              last_q, last_d;

  assign free_k   = free_q[kind_q];
  assign fill_k   = fill_q[kind_q];
  assign free_inc = (free_k == FreeMax) ? free_k : FreeW'(free_k + 1'b1);

  assign status_o.pop_needed = (op_q == OP_COMPLETE) && (fill_k != '0);

  assign ram_waddr = slot_addr(kind_q, tail_q[kind_q]);
  assign ram_raddr = slot_addr(kind_q, head_q[kind_q]);

  ufa_ram #(
    .Width (EntryW),
    .Depth (RamDepth)
  ) u_wait_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i ({dur_q, tag_q}),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    free_d  = free_q;
    head_d  = head_q;
    tail_d  = tail_q;
    fill_d  = fill_q;
    ram_we  = 1'b0;
    valid_d = 1'b0;
    rkind_d = RES_DONE;
    okind_d = kind_q;
    odur_d  = '0;
    otag_d  = tag_q;
    last_d  = 1'b1;

    if (cmd_i.exec) begin
      valid_d = 1'b1;
      if (op_q == OP_REQUEST) begin
        if (free_k != '0 && fill_k == '0) begin
          free_d[kind_q] = FreeW'(free_k - 1'b1);
          rkind_d        = RES_START;
          odur_d         = dur_q;
        end else if (fill_k != FillW'(QueueDepth)) begin
          ram_we         = 1'b1;
          tail_d[kind_q] = next_slot(tail_q[kind_q]);
          fill_d[kind_q] = FillW'(fill_k + 1'b1);
          rkind_d        = RES_QUEUED;
        end else begin
          rkind_d = RES_DROPPED;
        end
      end else begin
        rkind_d = RES_DONE;
        if (fill_k == '0) begin
          free_d[kind_q] = free_inc;
        end else begin
          // head leaves the queue now, its entry is read out for the next result
          last_d         = 1'b0;
          free_d[kind_q] = FreeW'(free_inc - 1'b1);
          head_d[kind_q] = next_slot(head_q[kind_q]);
          fill_d[kind_q] = FillW'(fill_k - 1'b1);
        end
      end
    end else if (cmd_i.pop) begin
      valid_d = 1'b1;
      rkind_d = RES_START;
      odur_d  = ram_rdata[EntryW-1:DataW];
      otag_d  = ram_rdata[DataW-1:0];
    end

    if (cfg_we_i) begin
      free_d[cfg_index_i] = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      for (int k = 0; k < NumKinds; k++) begin
        free_q[k] <= FreeReset;
        head_q[k] <= '0;
        tail_q[k] <= '0;
        fill_q[k] <= '0;
      end
    end else begin
      valid_q <= valid_d;
      free_q  <= free_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      fill_q  <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= op_e'(op_i);
      kind_q <= unit_kind_i;
      dur_q  <= duration_i;
      tag_q  <= tag_i;
    end
    if (valid_d) begin
      rkind_q <= rkind_d;
      okind_q <= okind_d;
      odur_q  <= odur_d;
      otag_q  <= otag_d;
      last_q  <= last_d;
    end
  end

  assign strobe_o       = valid_q;
  assign result_kind_o  = rkind_q;
  assign out_kind_o     = okind_q;
  assign out_duration_o = odur_q;
  assign out_tag_o      = otag_q;
  assign last_o         = last_q;

endmodule

FILE: rtl/unit_pool_fifo_admission_core.sv
// top level of the unit pool admission block
// An item is taken when start is high and busy is low. A request is latched, executed in
// the EXEC state and its result registered; busy is low again in the cycle that result is
// shown, and no new item is taken before then. A completion gives its done result at the
// same point; if a job was waiting for that kind, busy stays high through the POP state
// while the head entry is read from the wait store RAM (registered read), and the start
// result for that job follows in the next cycle. Results are shown for one cycle under
// strobe_o and cannot be held off, so they must be taken as they come.
// Configuration writes load the free unit counter of a kind directly.
module unit_pool_fifo_admission_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic                        op_i,
  input  logic [ufa_pkg::KindW-1:0]   unit_kind_i,
  input  logic [ufa_pkg::DataW-1:0]   duration_i,
  input  logic [ufa_pkg::DataW-1:0]   tag_i,
  input  logic                        cfg_we_i,
  input  logic [ufa_pkg::KindW-1:0]   cfg_index_i,
  input  logic [ufa_pkg::FreeW-1:0]   cfg_data_i,
  output logic                        strobe_o,
  output logic [1:0]                  result_kind_o,
  output logic [ufa_pkg::KindW-1:0]   out_kind_o,
  output logic [ufa_pkg::DataW-1:0]   out_duration_o,
  output logic [ufa_pkg::DataW-1:0]   out_tag_o,
  output logic                        last_o
);
  import ufa_pkg::*;

  cmd_t    cmd;
  status_t status;

  ufa_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy     (busy)
  );

  ufa_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .op_i           (op_i),
    .unit_kind_i    (unit_kind_i),
    .duration_i     (duration_i),
    .tag_i          (tag_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .strobe_o       (strobe_o),
    .result_kind_o  (result_kind_o),
    .out_kind_o     (out_kind_o),
    .out_duration_o (out_duration_o),
    .out_tag_o      (out_tag_o),
    .last_o         (last_o)
  );

  // a done result that is not last is always followed by the start of the queued job
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !last_o |=> strobe_o && last_o && (result_kind_o == RES_START))
    else $error("queued job start did not follow its done result");

  // only a completion leaves a result that is not last
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !last_o |-> (result_kind_o == RES_DONE))
    else $error("non-final result is not a done result");

  // results only come out when the block was busy in the cycle before
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> $past(busy))
    else $error("result without a transaction in progress");

  // a taken transaction always makes the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("transaction taken but block not busy");

endmodule

FILE: verif/unit_pool_fifo_admission_core_tb.sv
// self-checking testbench for unit_pool_fifo_admission_core: directed table, then random phases
module unit_pool_fifo_admission_core_tb;
  import ufa_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int NumPhases  = 6;
  localparam int PhaseItems = 170;
  localparam int DirRows    = 13;

  typedef struct packed {
    res_kind_e          rk;
    logic [KindW-1:0]   kind;
    logic [DataW-1:0]   dur;
    logic [DataW-1:0]   tag;
    logic               last;
  } admit_result_t;

  typedef struct packed {
    op_e                op;
    logic [KindW-1:0]   kind;
    logic [DataW-1:0]   dur;
    logic [DataW-1:0]   tag;
    logic [4:0]         reps;
    logic               typed;
    admit_result_t      want;
  } stim_row_t;

  localparam admit_result_t NoWant = '0;

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic               op_i;
  logic [KindW-1:0]   unit_kind_i;
  logic [DataW-1:0]   duration_i;
  logic [DataW-1:0]   tag_i;
  logic               cfg_we_i;
  logic [KindW-1:0]   cfg_index_i;
  logic [FreeW-1:0]   cfg_data_i;
  logic               strobe_o;
  logic [1:0]         result_kind_o;
  logic [KindW-1:0]   out_kind_o;
  logic [DataW-1:0]   out_duration_o;
  logic [DataW-1:0]   out_tag_o;
  logic               last_o;

  // admission state as the block should hold it
  logic [FreeW-1:0]   free_model     [NumKinds];
  logic [DataW-1:0]   wait_dur_model [NumKinds][QueueDepth];
  logic [DataW-1:0]   wait_tag_model [NumKinds][QueueDepth];
  logic [QIdxW-1:0]   head_model     [NumKinds];
  logic [QIdxW-1:0]   tail_model     [NumKinds];
  logic [FillW-1:0]   fill_model     [NumKinds];

  admit_result_t      expected_results [$];
  int                 mismatches = 0;
  int                 cycles = 0;
  int                 req_pct [NumPhases] = '{85, 35, 60, 50, 90, 45};

  // directed rows; kind 2 starts at 15 units and kind 3 at none
  stim_row_t dir_tab [DirRows] = '{
    '{OP_REQUEST,  2'd0, 32'h0000_0000, 32'h0000_0000, 5'd1, 1'b1,
      '{RES_START, 2'd0, 32'h0000_0000, 32'h0000_0000, 1'b1}},
    '{OP_REQUEST,  2'd0, 32'hffff_ffff, 32'hffff_ffff, 5'd1, 1'b1,
      '{RES_QUEUED, 2'd0, 32'h0000_0000, 32'hffff_ffff, 1'b1}},
    '{OP_REQUEST,  2'd0, 32'h1234_5678, 32'h0000_0100, 5'd15, 1'b0, NoWant},
    '{OP_REQUEST,  2'd0, 32'h0000_0005, 32'hdead_beef, 5'd1, 1'b1,
      '{RES_DROPPED, 2'd0, 32'h0000_0000, 32'hdead_beef, 1'b1}},
    '{OP_COMPLETE, 2'd0, 32'h0000_0000, 32'h0000_0000, 5'd1, 1'b0, NoWant},
    '{OP_COMPLETE, 2'd0, 32'hffff_ffff, 32'h0000_0001, 5'd1, 1'b0, NoWant},
    '{OP_REQUEST,  2'd1, 32'h0000_0007, 32'h0000_0001, 5'd1, 1'b1,
      '{RES_START, 2'd1, 32'h0000_0007, 32'h0000_0001, 1'b1}},
    '{OP_COMPLETE, 2'd1, 32'h0000_0000, 32'h0000_0001, 5'd1, 1'b1,
      '{RES_DONE, 2'd1, 32'h0000_0000, 32'h0000_0001, 1'b1}},
    '{OP_COMPLETE, 2'd1, 32'h0000_0000, 32'h0000_0002, 5'd1, 1'b1,
      '{RES_DONE, 2'd1, 32'h0000_0000, 32'h0000_0002, 1'b1}},
    '{OP_COMPLETE, 2'd2, 32'h0000_0000, 32'hffff_ffff, 5'd1, 1'b1,
      '{RES_DONE, 2'd2, 32'h0000_0000, 32'hffff_ffff, 1'b1}},
    '{OP_REQUEST,  2'd2, 32'h8000_0000, 32'h7fff_ffff, 5'd1, 1'b1,
      '{RES_START, 2'd2, 32'h8000_0000, 32'h7fff_ffff, 1'b1}},
    '{OP_REQUEST,  2'd3, 32'h0000_0001, 32'h0000_0002, 5'd1, 1'b1,
      '{RES_QUEUED, 2'd3, 32'h0000_0000, 32'h0000_0002, 1'b1}},
    '{OP_COMPLETE, 2'd3, 32'h0000_0000, 32'h0000_0003, 5'd1, 1'b0, NoWant}
  };

  unit_pool_fifo_admission_core uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .op_i           (op_i),
    .unit_kind_i    (unit_kind_i),
    .duration_i     (duration_i),
    .tag_i          (tag_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .strobe_o       (strobe_o),
    .result_kind_o  (result_kind_o),
    .out_kind_o     (out_kind_o),
    .out_duration_o (out_duration_o),
    .out_tag_o      (out_tag_o),
    .last_o         (last_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic void predict_admission(op_e op, logic [KindW-1:0] k,
                                            logic [DataW-1:0] dur, logic [DataW-1:0] tag);
    logic [QIdxW-1:0] h;
    if (op == OP_REQUEST) begin
      if (free_model[k] != 0 && fill_model[k] == 0) begin
        free_model[k] = free_model[k] - 1'b1;
        expected_results.push_back(admit_result_t'{RES_START, k, dur, tag, 1'b1});
      end else if (fill_model[k] < QueueDepth) begin
        wait_dur_model[k][tail_model[k]] = dur;
        wait_tag_model[k][tail_model[k]] = tag;
        tail_model[k] = tail_model[k] + 1'b1;
        fill_model[k] = fill_model[k] + 1'b1;
        expected_results.push_back(admit_result_t'{RES_QUEUED, k, '0, tag, 1'b1});
      end else begin
        expected_results.push_back(admit_result_t'{RES_DROPPED, k, '0, tag, 1'b1});
      end
    end else begin
      if (free_model[k] < FreeMax) free_model[k] = free_model[k] + 1'b1;
      if (fill_model[k] == 0) begin
        expected_results.push_back(admit_result_t'{RES_DONE, k, '0, tag, 1'b1});
      end else begin
        expected_results.push_back(admit_result_t'{RES_DONE, k, '0, tag, 1'b0});
        // head of the wait queue starts right behind the done report
        h = head_model[k];
        head_model[k] = head_model[k] + 1'b1;
        fill_model[k] = fill_model[k] - 1'b1;
        if (free_model[k] != 0) free_model[k] = free_model[k] - 1'b1;
        expected_results.push_back(admit_result_t'{RES_START, k, wait_dur_model[k][h],
                                                   wait_tag_model[k][h], 1'b1});
      end
    end
  endfunction

  function automatic void check_field(string name, logic [DataW-1:0] want,
                                      logic [DataW-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // one transaction: optional idle cycles, then hold start until busy is low
  task automatic send_item(input op_e op, input logic [KindW-1:0] k,
                           input logic [DataW-1:0] dur, input logic [DataW-1:0] tag,
                           input int idle);
    if (idle > 0) begin
      start <= 1'b0;
      repeat (idle) @(posedge clk_i);
    end
    start       <= 1'b1;
    op_i        <= op;
    unit_kind_i <= k;
    duration_i  <= dur;
    tag_i       <= tag;
    do @(posedge clk_i); while (busy);
    predict_admission(op, k, dur, tag);
  endtask

  task automatic load_counts(input logic [NumKinds-1:0][FreeW-1:0] counts);
    for (int i = 0; i < NumKinds; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= KindW'(i);
      cfg_data_i  <= counts[i];
      @(posedge clk_i);
      free_model[i] = counts[i];
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_quiet();
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    admit_result_t want;
    if (rst_ni && strobe_o) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got kind %0d unit %0d tag %h",
                 $time, result_kind_o, out_kind_o, out_tag_o);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        check_field("result_kind", DataW'(want.rk), DataW'(result_kind_o));
        check_field("out_kind", DataW'(want.kind), DataW'(out_kind_o));
        check_field("out_duration", want.dur, out_duration_o);
        check_field("out_tag", want.tag, out_tag_o);
        check_field("last", DataW'(want.last), DataW'(last_o));
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    logic [NumKinds-1:0][FreeW-1:0] counts;
    logic [KindW-1:0] hot;
    logic [KindW-1:0] k;
    logic [DataW-1:0] dur;
    op_e op;
    int burst_left;
    int idle;

    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    start       = 1'b0;
    op_i        = 1'b0;
    unit_kind_i = '0;
    duration_i  = '0;
    tag_i       = '0;
    cfg_we_i    = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    for (int i = 0; i < NumKinds; i++) begin
      free_model[i] = FreeReset;
      head_model[i] = '0;
      tail_model[i] = '0;
      fill_model[i] = '0;
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    load_counts({4'd0, 4'd15, 4'd1, 4'd1});
    for (int r = 0; r < DirRows; r++) begin
      for (int n = 0; n < dir_tab[r].reps; n++) begin
        send_item(dir_tab[r].op, dir_tab[r].kind, dir_tab[r].dur, dir_tab[r].tag + n,
                  $urandom_range(2));
        if (dir_tab[r].typed) expected_results[expected_results.size() - 1] = dir_tab[r].want;
      end
    end
    wait_quiet();

    for (int p = 0; p < NumPhases; p++) begin
      if (p == 0) counts = '0;
      else if (p == 1) counts = {NumKinds{4'd15}};
      else for (int i = 0; i < NumKinds; i++) counts[i] = FreeW'($urandom_range(15));
      load_counts(counts);
      // most traffic on one kind so its queue fills and drains
      hot = KindW'($urandom_range(3));
      burst_left = 0;
      for (int n = 0; n < PhaseItems; n++) begin
        idle = 0;
        if (burst_left == 0) begin
          burst_left = $urandom_range(24, 1);
          if (p != 2 && $urandom_range(3) != 0) idle = $urandom_range(6, 1);
        end
        burst_left--;
        op = ($urandom_range(99) < req_pct[p]) ? OP_REQUEST : OP_COMPLETE;
        k = ($urandom_range(99) < 60) ? hot : KindW'($urandom_range(3));
        case ($urandom_range(7))
          0: dur = '0;
          1: dur = '1;
          default: dur = $urandom;
        endcase
        send_item(op, k, dur, $urandom, idle);
      end
      wait_quiet();
    end

    repeat (6) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
